// ===== design/lgpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lgpc_pkg
// Shared constants and types of the layered glyph pixel compositor.
// ----------------------------------------------------------------------------
package lgpc_pkg;

    localparam int GLYPH_WIDTH    = 8;
    localparam int GLYPH_HEIGHT   = 16;
    localparam int BASE_GLYPHS    = 256;
    localparam int OVERLAY_GLYPHS = 1024;

    // one base entry is one glyph row, one overlay entry is one glyph row (2 bpp)
    localparam int BASE_ROW_W = GLYPH_WIDTH;
    localparam int OVL_ROW_W  = 2 * GLYPH_WIDTH;
    localparam int COL_W      = $clog2(GLYPH_WIDTH);
    localparam int OSH_W      = $clog2(OVL_ROW_W);

    localparam int BASE_DEPTH = BASE_GLYPHS * GLYPH_HEIGHT;
    localparam int OVL_DEPTH  = OVERLAY_GLYPHS * GLYPH_HEIGHT;
    localparam int BASE_AW    = (BASE_DEPTH > 1) ? $clog2(BASE_DEPTH) : 1;
    localparam int OVL_AW     = (OVL_DEPTH > 1) ? $clog2(OVL_DEPTH) : 1;

    localparam int CLR_DEPTH = (BASE_DEPTH > OVL_DEPTH) ? BASE_DEPTH : OVL_DEPTH;
    localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

    typedef enum logic [2:0] {
        FN_WR_BASE   = 3'd0,
        FN_WR_OVL    = 3'd1,
        FN_RD_BASE   = 3'd2,
        FN_RD_OVL    = 3'd3,
        FN_COMPOSITE = 3'd4
    } func_t;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

    // transaction held while its rows come back from the stores
    typedef struct packed {
        func_t                 func;
        logic [COL_W-1:0]      bcol;
        logic [COL_W-1:0]      ocol;
        logic [1:0]            val;
        logic                  rev;
        logic                  none;
        logic                  b_ok;
        logic                  o_ok;
        logic                  in_range;
        logic [BASE_AW-1:0]    base_addr;
        logic [OVL_AW-1:0]     ovl_addr;
    } stage_t;

endpackage

// ===== design/lgpc_ram.sv =====
// ----------------------------------------------------------------------------
// lgpc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lgpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/layered_glyph_pixel_compositor.sv =====
// ----------------------------------------------------------------------------
// layered_glyph_pixel_compositor
// Two glyph stores (1 bpp base, 2 bpp overlay) with pixel read, write and
// composite operations on a streaming interface.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps both stores to zero, one row per cycle
// (CLR_DEPTH rows, 16384 with the default sizes), with s_tready low.
// It then takes one transaction per cycle unless m_tready stalls the output:
// each item reads its base row and overlay row from the stores in the accept
// cycle, the result is formed and any write back done in the result stage,
// and the result then sits in the output register that drives m_tvalid.
// The rate is set by the single read port of each store; a write followed at
// once by an access to the same row is covered by forwarding the last row
// written. Every item, also a write or an unused func code, gives one result.
// ----------------------------------------------------------------------------
module layered_glyph_pixel_compositor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [9:0] glyph_index, [13:10] x, [18:14] y, [20:19] pixel_value,
    // [28:21] base_index, [38:29] overlay_index, [39] hflip, [40] vflip,
    // [41] reverse, [42] no_glyph, [47:43] zero
    input  logic [47:0] s_tdata,
    // [2:0] func
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] pixel, [3] in_range, [7:4] zero
    output logic [7:0]  m_tdata
);

    // ------------------------------------------------------------------
    // input field unpack
    // ------------------------------------------------------------------
    lgpc_pkg::func_t a_func;
    logic [9:0]      a_g;
    logic [3:0]      a_x;
    logic [4:0]      a_y;
    logic [1:0]      a_val;
    logic [7:0]      a_bi;
    logic [9:0]      a_oi;
    logic            a_hflip;
    logic            a_vflip;
    logic            a_rev;
    logic            a_none;

    assign a_func  = lgpc_pkg::func_t'(s_tuser);
    assign a_g     = s_tdata[9:0];
    assign a_x     = s_tdata[13:10];
    assign a_y     = s_tdata[18:14];
    assign a_val   = s_tdata[20:19];
    assign a_bi    = s_tdata[28:21];
    assign a_oi    = s_tdata[38:29];
    assign a_hflip = s_tdata[39];
    assign a_vflip = s_tdata[40];
    assign a_rev   = s_tdata[41];
    assign a_none  = s_tdata[42];

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    lgpc_pkg::state_t               state_reg, state_next;
    logic [lgpc_pkg::CLR_W-1:0]     clr_cnt_reg, clr_cnt_next;

    logic                           b_valid_reg;
    lgpc_pkg::stage_t               b_reg;
    logic                           out_valid_reg;
    logic [2:0]                     out_pixel_reg;
    logic                           out_range_reg;

    // last row written to each store, for a read issued on the write edge
    logic                           lb_valid_reg;
    logic [lgpc_pkg::BASE_AW-1:0]   lb_addr_reg;
    logic [lgpc_pkg::BASE_ROW_W-1:0] lb_data_reg;
    logic                           lo_valid_reg;
    logic [lgpc_pkg::OVL_AW-1:0]    lo_addr_reg;
    logic [lgpc_pkg::OVL_ROW_W-1:0] lo_data_reg;

    logic accept;
    logic b_fire;

    assign s_tready = (state_reg == lgpc_pkg::ST_RUN) && (!b_valid_reg || b_fire);
    assign accept   = s_tvalid && s_tready;
    assign b_fire   = b_valid_reg && (!out_valid_reg || m_tready);

    // ------------------------------------------------------------------
    // accept stage: bounds, flips, row addresses
    // ------------------------------------------------------------------
    logic             a_comp;
    logic [9:0]       a_bg;
    logic [9:0]       a_og;
    logic [4:0]       a_oy;
    logic             a_xy_ok;
    lgpc_pkg::stage_t a_stage;

    always_comb
    begin
        a_comp  = (a_func == lgpc_pkg::FN_COMPOSITE);
        a_bg    = a_comp ? {2'b00, a_bi} : a_g;
        a_og    = a_comp ? a_oi : a_g;
        a_xy_ok = (a_x < lgpc_pkg::GLYPH_WIDTH) && (a_y < lgpc_pkg::GLYPH_HEIGHT);
        a_oy    = (a_comp && a_vflip) ? 5'(lgpc_pkg::GLYPH_HEIGHT - 1) - a_y : a_y;

        a_stage.func = a_func;
        a_stage.bcol = a_x[lgpc_pkg::COL_W-1:0];
        a_stage.ocol = (a_comp && a_hflip)
                     ? lgpc_pkg::COL_W'(lgpc_pkg::GLYPH_WIDTH - 1) - a_x[lgpc_pkg::COL_W-1:0]
                     : a_x[lgpc_pkg::COL_W-1:0];
        a_stage.val  = a_val;
        a_stage.rev  = a_rev;
        a_stage.none = a_none;
        a_stage.b_ok = (a_bg < lgpc_pkg::BASE_GLYPHS) && a_xy_ok;
        a_stage.o_ok = (a_og < lgpc_pkg::OVERLAY_GLYPHS) && a_xy_ok;
        a_stage.base_addr = lgpc_pkg::BASE_AW'(a_bg * lgpc_pkg::GLYPH_HEIGHT + a_y);
        a_stage.ovl_addr  = lgpc_pkg::OVL_AW'(a_og * lgpc_pkg::GLYPH_HEIGHT + a_oy);

        unique case (a_func)
            lgpc_pkg::FN_WR_BASE,
            lgpc_pkg::FN_RD_BASE:   a_stage.in_range = a_stage.b_ok;
            lgpc_pkg::FN_WR_OVL,
            lgpc_pkg::FN_RD_OVL:    a_stage.in_range = a_stage.o_ok;
            lgpc_pkg::FN_COMPOSITE: a_stage.in_range = a_stage.b_ok && a_stage.o_ok;
            default:                a_stage.in_range = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // stores
    // ------------------------------------------------------------------
    logic                            base_we_mux;
    logic [lgpc_pkg::BASE_AW-1:0]    base_waddr_mux;
    logic [lgpc_pkg::BASE_ROW_W-1:0] base_wdata_mux;
    logic [lgpc_pkg::BASE_ROW_W-1:0] base_rdata;
    logic                            ovl_we_mux;
    logic [lgpc_pkg::OVL_AW-1:0]     ovl_waddr_mux;
    logic [lgpc_pkg::OVL_ROW_W-1:0]  ovl_wdata_mux;
    logic [lgpc_pkg::OVL_ROW_W-1:0]  ovl_rdata;

    lgpc_ram #(
        .WIDTH (lgpc_pkg::BASE_ROW_W),
        .DEPTH (lgpc_pkg::BASE_DEPTH)
    ) u_base_ram (
        .clk   (clk),
        .we    (base_we_mux),
        .waddr (base_waddr_mux),
        .wdata (base_wdata_mux),
        .re    (accept),
        .raddr (a_stage.base_addr),
        .rdata (base_rdata)
    );

    lgpc_ram #(
        .WIDTH (lgpc_pkg::OVL_ROW_W),
        .DEPTH (lgpc_pkg::OVL_DEPTH)
    ) u_ovl_ram (
        .clk   (clk),
        .we    (ovl_we_mux),
        .waddr (ovl_waddr_mux),
        .wdata (ovl_wdata_mux),
        .re    (accept),
        .raddr (a_stage.ovl_addr),
        .rdata (ovl_rdata)
    );

    // ------------------------------------------------------------------
    // result stage: forward, extract, modify
    // ------------------------------------------------------------------
    logic [lgpc_pkg::BASE_ROW_W-1:0] brow;
    logic [lgpc_pkg::BASE_ROW_W-1:0] bmask;
    logic [lgpc_pkg::BASE_ROW_W-1:0] base_wnew;
    logic [lgpc_pkg::COL_W-1:0]      bpos;
    logic                            bpix;
    logic [lgpc_pkg::OVL_ROW_W-1:0]  orow;
    logic [lgpc_pkg::OVL_ROW_W-1:0]  osh;
    logic [lgpc_pkg::OVL_ROW_W-1:0]  omask;
    logic [lgpc_pkg::OVL_ROW_W-1:0]  ovl_wnew;
    logic [lgpc_pkg::OSH_W-1:0]      oshift;
    logic [1:0]                      oval;
    logic [1:0]                      ov;
    logic [2:0]                      b_pixel;
    logic                            b_base_we;
    logic                            b_ovl_we;

    always_comb
    begin
        brow = (lb_valid_reg && (lb_addr_reg == b_reg.base_addr)) ? lb_data_reg : base_rdata;
        orow = (lo_valid_reg && (lo_addr_reg == b_reg.ovl_addr)) ? lo_data_reg : ovl_rdata;

        // leftmost column in the top bits of a row
        bpos   = lgpc_pkg::COL_W'(lgpc_pkg::GLYPH_WIDTH - 1) - b_reg.bcol;
        bmask  = lgpc_pkg::BASE_ROW_W'(1) << bpos;
        bpix   = b_reg.b_ok && brow[bpos];
        oshift = lgpc_pkg::OSH_W'(lgpc_pkg::OVL_ROW_W - 2) - {b_reg.ocol, 1'b0};
        osh    = orow >> oshift;
        oval   = b_reg.o_ok ? osh[1:0] : 2'b00;
        omask  = lgpc_pkg::OVL_ROW_W'(3) << oshift;

        base_wnew = (b_reg.val != 2'b00) ? (brow | bmask) : (brow & ~bmask);
        ovl_wnew  = (orow & ~omask) | (lgpc_pkg::OVL_ROW_W'(b_reg.val) << oshift);

        ov        = oval;
        b_pixel   = 3'd0;
        b_base_we = 1'b0;
        b_ovl_we  = 1'b0;
        unique case (b_reg.func)
            lgpc_pkg::FN_WR_BASE: b_base_we = b_reg.b_ok;
            lgpc_pkg::FN_WR_OVL:  b_ovl_we  = b_reg.o_ok;
            lgpc_pkg::FN_RD_BASE: b_pixel   = {2'b00, bpix};
            lgpc_pkg::FN_RD_OVL:  b_pixel   = {1'b0, oval};
            lgpc_pkg::FN_COMPOSITE:
            begin
                if (b_reg.none)
                begin
                    b_pixel = 3'd0;
                end
                else if (ov == 2'b00)
                begin
                    // transparent overlay: base shows through
                    b_pixel = {2'b00, bpix ^ b_reg.rev};
                end
                else
                begin
                    b_pixel = {1'b0, ov} + 3'd1;
                end
            end
            default: b_pixel = 3'd0;
        endcase
    end

    // store write ports: clear sweep after reset, else write back
    always_comb
    begin
        if (state_reg == lgpc_pkg::ST_CLEAR)
        begin
            base_we_mux    = (clr_cnt_reg < lgpc_pkg::BASE_DEPTH);
            base_waddr_mux = clr_cnt_reg[lgpc_pkg::BASE_AW-1:0];
            base_wdata_mux = '0;
            ovl_we_mux     = (clr_cnt_reg < lgpc_pkg::OVL_DEPTH);
            ovl_waddr_mux  = clr_cnt_reg[lgpc_pkg::OVL_AW-1:0];
            ovl_wdata_mux  = '0;
        end
        else
        begin
            base_we_mux    = b_fire && b_base_we;
            base_waddr_mux = b_reg.base_addr;
            base_wdata_mux = base_wnew;
            ovl_we_mux     = b_fire && b_ovl_we;
            ovl_waddr_mux  = b_reg.ovl_addr;
            ovl_wdata_mux  = ovl_wnew;
        end
    end

    // ------------------------------------------------------------------
    // clear sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            lgpc_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == lgpc_pkg::CLR_W'(lgpc_pkg::CLR_DEPTH - 1))
                begin
                    state_next = lgpc_pkg::ST_RUN;
                end
            end
            lgpc_pkg::ST_RUN:
            begin
                clr_cnt_next = clr_cnt_reg;
            end
            default:
            begin
                state_next = lgpc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lgpc_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            lb_valid_reg  <= 1'b0;
            lo_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_fire)
            begin
                b_valid_reg <= 1'b0;
            end

            if (b_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (b_fire && b_base_we)
            begin
                lb_valid_reg <= 1'b1;
            end
            if (b_fire && b_ovl_we)
            begin
                lo_valid_reg <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_reg <= a_stage;
        end
        if (b_fire)
        begin
            out_pixel_reg <= b_pixel;
            out_range_reg <= b_reg.in_range;
        end
        if (b_fire && b_base_we)
        begin
            lb_addr_reg <= b_reg.base_addr;
            lb_data_reg <= base_wnew;
        end
        if (b_fire && b_ovl_we)
        begin
            lo_addr_reg <= b_reg.ovl_addr;
            lo_data_reg <= ovl_wnew;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_range_reg, out_pixel_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> b_valid_reg)
        else $error("accepted transaction did not reach the result stage");

    a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
        b_fire |=> m_tvalid)
        else $error("result stage fired without an output transaction");

    a_no_stray_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lgpc_pkg::ST_RUN && !b_fire) |-> (!base_we_mux && !ovl_we_mux))
        else $error("store written with no transaction retiring");

    a_pixel_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] <= 3'd4))
        else $error("pixel code out of range");

endmodule
